[hdl/bpra_pkg.sv]
// Shared types and constants for the bitmap page run allocator.
// Used by bpra_ctrl, bpra_datapath and bitmap_page_run_allocator; no dependencies.
package bpra_pkg;

  // Defaults for the top-level parameters
  localparam int POOL_PAGES_MAX_DEF = 4096;
  localparam int PAGE_SHIFT_DEF     = 12;

  // Fixed field widths
  localparam int OPCODE_W   = 2;
  localparam int COUNT_W    = 13;
  localparam int ADDR_W     = 32;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [COUNT_W-1:0] POOL_PAGES_RESET = COUNT_W'(4096);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDR  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_PAGES = 1'b1;

  // Bitmap memory organization: 64 pages per row, scanned 8 pages per cycle
  localparam int ROW_W      = 64;
  localparam int ROW_SHIFT  = $clog2(ROW_W);
  localparam int LANE_W     = 8;
  localparam int LANE_SHIFT = $clog2(LANE_W);
  localparam int SUB_W      = ROW_SHIFT - LANE_SHIFT;
  localparam logic [SUB_W-1:0] SUB_LAST = '1;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_CLAIM = 2'd2
  } bpra_op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_BAD      = 2'd2
  } bpra_status_t;

  // Controller to datapath
  typedef struct packed {
    logic         clr_step;
    logic         req_load;
    logic         off_calc;
    logic         scan_init;
    logic         scan_step;
    logic         range_load;
    logic         range_from_scan;
    logic         mark_load;
    logic         mark_step;
    logic         out_load;
    bpra_status_t out_status;
  } bpra_cmd_t;

  // Datapath to controller
  typedef struct packed {
    bpra_op_t op;
    logic     cnt_zero;
    logic     free_ok;
    logic     claim_ok;
    logic     found;
    logic     scan_last;
    logic     mark_last;
    logic     clr_last;
  } bpra_stat_t;

endpackage

[hdl/bitmap_page_run_allocator.sv]
// Top level of the bitmap page run allocator.
// Depends on bpra_pkg, bpra_ctrl and bpra_datapath.

// One request at a time. After reset the bitmap is cleared one 64-page row per
// cycle, with in_stall high. Alloc scans the bitmap first fit from page 0, 8
// pages per cycle, then marks the run in a single read-modify-write pass over
// the bitmap rows. Free and claim skip the scan and do only the mark pass; a
// rejected request skips both. The result sits in an output register, so a new
// request is taken while it waits downstream.
module bitmap_page_run_allocator #(
  parameter int POOL_PAGES_MAX = bpra_pkg::POOL_PAGES_MAX_DEF,
  parameter int PAGE_SHIFT     = bpra_pkg::PAGE_SHIFT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [bpra_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bpra_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [bpra_pkg::OPCODE_W-1:0]    opcode,
  input  logic [bpra_pkg::COUNT_W-1:0]     page_count,
  input  logic [bpra_pkg::ADDR_W-1:0]      page_addr,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [bpra_pkg::ADDR_W-1:0]      result_addr,
  output logic [bpra_pkg::STATUS_W-1:0]    status
);
  import bpra_pkg::*;

  bpra_cmd_t  cmd;
  bpra_stat_t stat;

  bpra_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  bpra_datapath #(
    .POOL_PAGES_MAX (POOL_PAGES_MAX),
    .PAGE_SHIFT     (PAGE_SHIFT)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .opcode      (opcode),
    .page_count  (page_count),
    .page_addr   (page_addr),
    .cmd         (cmd),
    .stat        (stat),
    .result_addr (result_addr),
    .status      (status)
  );

endmodule

[hdl/bpra_ctrl.sv]
// Controller state machine for the bitmap page run allocator.
// Depends on bpra_pkg; drives bpra_datapath through bpra_cmd_t.
module bpra_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  bpra_pkg::bpra_stat_t stat,
  output bpra_pkg::bpra_cmd_t  cmd
);
  import bpra_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_OFFSET,
    S_CHECK,
    S_SCAN,
    S_MARK_LOAD,
    S_MARK,
    S_DONE
  } state_t;

  state_t       state;
  bpra_status_t fin_status;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.out_status = fin_status;
    unique case (state)
      S_CLEAR:     cmd.clr_step = 1'b1;
      S_IDLE:      cmd.req_load = in_valid;
      S_OFFSET:    cmd.off_calc = 1'b1;
      S_CHECK: begin
        unique case (stat.op)
          OP_ALLOC: cmd.scan_init  = !stat.cnt_zero;
          OP_FREE:  cmd.range_load = stat.free_ok;
          OP_CLAIM: cmd.range_load = stat.claim_ok;
          default:  cmd.range_load = 1'b0;
        endcase
      end
      S_SCAN: begin
        cmd.scan_step       = 1'b1;
        cmd.range_load      = stat.found;
        cmd.range_from_scan = 1'b1;
      end
      S_MARK_LOAD: cmd.mark_load = 1'b1;
      S_MARK:      cmd.mark_step = 1'b1;
      S_DONE:      cmd.out_load  = !out_valid || !out_stall;
      default:     cmd.clr_step  = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      out_valid  <= 1'b0;
      fin_status <= ST_OK;
    end else begin
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          if (stat.clr_last) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) state <= S_OFFSET;
        end
        S_OFFSET: state <= S_CHECK;
        S_CHECK: begin
          unique case (stat.op)
            OP_ALLOC: begin
              if (stat.cnt_zero) begin
                fin_status <= ST_BAD;
                state      <= S_DONE;
              end else begin
                state <= S_SCAN;
              end
            end
            OP_FREE: begin
              fin_status <= stat.free_ok ? ST_OK : ST_BAD;
              state      <= stat.free_ok ? S_MARK_LOAD : S_DONE;
            end
            OP_CLAIM: begin
              fin_status <= stat.claim_ok ? ST_OK : ST_BAD;
              state      <= stat.claim_ok ? S_MARK_LOAD : S_DONE;
            end
            default: begin
              fin_status <= ST_BAD;
              state      <= S_DONE;
            end
          endcase
        end
        S_SCAN: begin
          if (stat.found) begin
            fin_status <= ST_OK;
            state      <= S_MARK_LOAD;
          end else if (stat.scan_last) begin
            fin_status <= ST_NO_SPACE;
            state      <= S_DONE;
          end
        end
        S_MARK_LOAD: state <= S_MARK;
        S_MARK: begin
          if (stat.mark_last) state <= S_DONE;
        end
        S_DONE: begin
          if (cmd.out_load) state <= S_IDLE;
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  // A result is never loaded over one that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("result register overwritten");

  // One request at a time: after a transfer in, the input side is closed
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second request accepted while busy");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_DONE))
    else $error("result presented outside the finish step");

endmodule

[hdl/bpra_datapath.sv]
// Datapath for the bitmap page run allocator: config registers, request
// registers, the used-page bitmap memory, the first-fit scan and the mark pass.
// Depends on bpra_pkg; controlled by bpra_ctrl.
module bpra_datapath #(
  parameter int POOL_PAGES_MAX = bpra_pkg::POOL_PAGES_MAX_DEF,
  parameter int PAGE_SHIFT     = bpra_pkg::PAGE_SHIFT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [bpra_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bpra_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [bpra_pkg::OPCODE_W-1:0]    opcode,
  input  logic [bpra_pkg::COUNT_W-1:0]     page_count,
  input  logic [bpra_pkg::ADDR_W-1:0]      page_addr,
  input  bpra_pkg::bpra_cmd_t              cmd,
  output bpra_pkg::bpra_stat_t             stat,
  output logic [bpra_pkg::ADDR_W-1:0]      result_addr,
  output logic [bpra_pkg::STATUS_W-1:0]    status
);
  import bpra_pkg::*;

  localparam int PW    = $clog2(POOL_PAGES_MAX + 1);
  localparam int CW    = (PW > COUNT_W) ? PW : COUNT_W;
  localparam int ROWS  = (POOL_PAGES_MAX + ROW_W - 1) / ROW_W;
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int OFF_W = ADDR_W - PAGE_SHIFT;

  localparam logic [CW-1:0] MAX_PAGES = CW'(POOL_PAGES_MAX);
  localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);

  logic [ADDR_W-1:0]  base_addr;
  logic [COUNT_W-1:0] pool_pages;
  logic [CW-1:0]      n_pages;

  bpra_op_t           req_op;
  logic [COUNT_W-1:0] req_cnt;
  logic [ADDR_W-1:0]  req_addr;
  logic [CW-1:0]      cnt_w;
  logic [OFF_W-1:0]   off_q;
  logic               below_q;
  logic               in_pool;
  logic               fits;

  logic [ROW_W-1:0]   bitmap_mem [ROWS];
  logic [ROW_W-1:0]   row_q;
  logic [ROW_W-1:0]   wr_data;
  logic               wr_en;
  logic               rd_en;
  logic [RW-1:0]      rd_addr;
  logic [RW-1:0]      row;
  logic [SUB_W-1:0]   sub;

  logic [LANE_W-1:0]     lane;
  logic [CW-1:0]         p0;
  logic [CW-1:0]         run;
  logic [CW-1:0]         run_next;
  logic                  hit;
  logic [LANE_SHIFT-1:0] hit_j;
  logic [CW-1:0]         hit_idx;
  logic [CW:0]           scan_end;

  logic [CW-1:0]      range_lo;
  logic [CW-1:0]      range_len;
  logic [CW-1:0]      lo;
  logic [CW-1:0]      hi;
  logic [CW-1:0]      last_pg;
  logic [RW-1:0]      lo_row;
  logic [RW-1:0]      last_row;
  logic [ROW_W-1:0]   lo_mask;
  logic [ROW_W-1:0]   hi_mask;
  logic [ROW_W-1:0]   mark_mask;

  // Configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      base_addr  <= '0;
      pool_pages <= POOL_PAGES_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BASE_ADDR:  base_addr  <= cfg_data;
        CFG_POOL_PAGES: pool_pages <= cfg_data[COUNT_W-1:0];
        default:        base_addr  <= base_addr;
      endcase
    end
  end

  assign n_pages = (CW'(pool_pages) > MAX_PAGES) ? MAX_PAGES : CW'(pool_pages);
  assign cnt_w   = CW'(req_cnt);

  // Request checks for free and claim
  assign in_pool = !below_q && (ADDR_W'(off_q) < ADDR_W'(n_pages));
  assign fits    = ADDR_W'(req_cnt) <= (ADDR_W'(n_pages) - ADDR_W'(off_q));

  // First-fit scan, one lane of pages per cycle
  always_comb begin
    lane     = row_q[sub*LANE_W +: LANE_W];
    p0       = CW'({row, sub, {LANE_SHIFT{1'b0}}});
    run_next = run;
    hit      = 1'b0;
    hit_j    = '0;
    for (int j = 0; j < LANE_W; j++) begin
      if (!hit && ((p0 + CW'(j)) < n_pages)) begin
        run_next = lane[j] ? '0 : run_next + 1'b1;
        if (run_next == cnt_w) begin
          hit   = 1'b1;
          hit_j = LANE_SHIFT'(j);
        end
      end
    end
    // run ends at p0 + hit_j, so it starts cnt - 1 pages earlier
    hit_idx  = p0 + CW'(hit_j) + CW'(1) - cnt_w;
    scan_end = {1'b0, p0} + (CW + 1)'(LANE_W);
  end

  // Run bounds and per-row masks for the mark pass
  assign range_lo  = cmd.range_from_scan ? hit_idx : CW'(off_q);
  assign range_len = (req_op == OP_CLAIM) ? CW'(1) : cnt_w;
  assign last_pg   = hi - 1'b1;
  assign lo_row    = RW'(lo >> ROW_SHIFT);
  assign last_row  = RW'(last_pg >> ROW_SHIFT);
  assign lo_mask   = (row == lo_row) ? ({ROW_W{1'b1}} << lo[ROW_SHIFT-1:0]) : '1;
  assign hi_mask   = (row == last_row)
                   ? ({ROW_W{1'b1}} >> (ROW_SHIFT'(ROW_W - 1) - last_pg[ROW_SHIFT-1:0]))
                   : '1;
  assign mark_mask = lo_mask & hi_mask;

  // Memory port control
  always_comb begin
    wr_en   = cmd.clr_step || cmd.mark_step;
    wr_data = '0;
    if (cmd.mark_step) begin
      wr_data = (req_op == OP_FREE) ? (row_q & ~mark_mask) : (row_q | mark_mask);
    end
    rd_en   = 1'b0;
    rd_addr = row + 1'b1;
    priority if (cmd.scan_init) begin
      rd_en   = 1'b1;
      rd_addr = '0;
    end else if (cmd.scan_step) begin
      rd_en = (sub == SUB_LAST) && !stat.scan_last;
    end else if (cmd.mark_load) begin
      rd_en   = 1'b1;
      rd_addr = lo_row;
    end else if (cmd.mark_step) begin
      rd_en = !stat.mark_last;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) bitmap_mem[row] <= wr_data;
    if (rd_en) row_q <= bitmap_mem[rd_addr];
  end

  // Row and lane position; also the clearing pass counter after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      sub <= '0;
    end else begin
      priority if (cmd.clr_step || cmd.mark_step) begin
        row <= row + 1'b1;
      end else if (cmd.scan_init) begin
        row <= '0;
        sub <= '0;
      end else if (cmd.scan_step) begin
        sub <= sub + 1'b1;
        if (sub == SUB_LAST) row <= row + 1'b1;
      end else if (cmd.mark_load) begin
        row <= lo_row;
      end
    end
  end

  // Request, scan and result registers
  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      req_op   <= bpra_op_t'(opcode);
      req_cnt  <= page_count;
      req_addr <= page_addr;
    end
    if (cmd.off_calc) begin
      below_q <= req_addr < base_addr;
      off_q   <= OFF_W'((req_addr - base_addr) >> PAGE_SHIFT);
    end
    if (cmd.scan_init) run <= '0;
    else if (cmd.scan_step) run <= run_next;
    if (cmd.range_load) begin
      lo <= range_lo;
      hi <= range_lo + range_len;
    end
    if (cmd.out_load) begin
      result_addr <= (cmd.out_status == ST_OK)
                   ? base_addr + (ADDR_W'(lo) << PAGE_SHIFT) : '0;
      status      <= cmd.out_status;
    end
  end

  always_comb begin
    stat           = '0;
    stat.op        = req_op;
    stat.cnt_zero  = (req_cnt == '0);
    stat.free_ok   = (req_cnt != '0) && in_pool && fits;
    stat.claim_ok  = in_pool;
    stat.found     = hit;
    stat.scan_last = scan_end >= {1'b0, n_pages};
    stat.mark_last = (row == last_row);
    stat.clr_last  = (row == LAST_ROW);
  end

  a_range_in_pool: assert property (@(posedge clk) disable iff (rst)
    cmd.mark_load |-> (lo < hi) && (hi <= n_pages))
    else $error("mark range empty or past pool end");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.range_load && cmd.range_from_scan) |=> (hi <= n_pages) && ((hi - lo) == cnt_w))
    else $error("scan hit gives a bad run");

  a_mark_row: assert property (@(posedge clk) disable iff (rst)
    cmd.mark_step |-> (row >= lo_row) && (row <= last_row))
    else $error("mark pass writes a row outside the run");

endmodule
